// ===== rtl/vertex_normal_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator assertion macros
// Shared property wrappers, clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define VNA_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define VNA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Codes, widths and the command beat passed from the front to the back.
// ----------------------------------------------------------------------------
package vna_pkg;

   localparam int MAX_VERTICES_DEFAULT = 1024;
   localparam int IDX_W                = 10;
   localparam int COORD_W              = 24;
   localparam int NORMAL_W             = 16;
   localparam int SCALE_W              = 16;
   localparam int QUEUE_DEPTH          = 2;
   localparam int CSR_ADDR_W           = 3;
   localparam int CSR_DATA_W           = 32;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

   // Register index
   localparam logic [0:0] REG_POSITION_SCALE = 1'b0;

   // Input modes
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TRI  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // Result status
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_UNLOADED = 2'd2;

   // Work kinds for the back end
   localparam logic [1:0] KIND_DONE = 2'd0;
   localparam logic [1:0] KIND_LOAD = 2'd1;
   localparam logic [1:0] KIND_TRI  = 2'd2;
   localparam logic [1:0] KIND_READ = 2'd3;

   typedef struct packed {
      logic [1:0]                kind;
      logic [1:0]                status;
      logic [IDX_W-1:0]          vidx;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [IDX_W-1:0]          corner_a;
      logic [IDX_W-1:0]          corner_b;
      logic [IDX_W-1:0]          corner_c;
   } cmd_type;

endpackage

// ===== rtl/vna_front.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator front end
// Accepts input beats, tracks the loaded vertex count and classifies each
// beat into a command for the back end.
// ----------------------------------------------------------------------------
module vna_front
   import vna_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_mode,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   input  logic [IDX_W-1:0]          req_corner_a,
   input  logic [IDX_W-1:0]          req_corner_b,
   input  logic [IDX_W-1:0]          req_corner_c,
   input  logic                      queue_full,
   output logic                      queue_push,
   output cmd_type                   queue_cmd
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] count_ext;
   logic             store_full;
   logic             a_bad;
   logic             b_bad;
   logic             c_bad;
   logic             accept;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign queue_push = accept;

   assign count_ext  = CMP_W'(count_ff);
   assign store_full = (count_ff == CNT_W'(MAX_VERTICES));
   assign a_bad      = (CMP_W'(req_corner_a) >= count_ext);
   assign b_bad      = (CMP_W'(req_corner_b) >= count_ext);
   assign c_bad      = (CMP_W'(req_corner_c) >= count_ext);

   // Classify the beat
   always_comb begin
      queue_cmd.kind     = KIND_DONE;
      queue_cmd.status   = STATUS_UNLOADED;
      queue_cmd.vidx     = '0;
      queue_cmd.coord_x  = req_coord_x;
      queue_cmd.coord_y  = req_coord_y;
      queue_cmd.coord_z  = req_coord_z;
      queue_cmd.corner_a = req_corner_a;
      queue_cmd.corner_b = req_corner_b;
      queue_cmd.corner_c = req_corner_c;
      count_in           = count_ff;
      case (req_mode)
         MODE_LOAD: begin
            if (store_full) begin
               queue_cmd.status = STATUS_FULL;
            end else begin
               queue_cmd.kind   = KIND_LOAD;
               queue_cmd.status = STATUS_OK;
               queue_cmd.vidx   = count_ext[IDX_W-1:0];
               if (accept) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         MODE_TRI: begin
            queue_cmd.vidx = req_corner_a;
            if (!(a_bad || b_bad || c_bad)) begin
               queue_cmd.kind   = KIND_TRI;
               queue_cmd.status = STATUS_OK;
            end
         end
         MODE_READ: begin
            queue_cmd.vidx = req_corner_a;
            if (!a_bad) begin
               queue_cmd.kind   = KIND_READ;
               queue_cmd.status = STATUS_OK;
            end
         end
         default: begin
            queue_cmd.status = STATUS_UNLOADED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/vna_queue.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator command queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module vna_queue
   import vna_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    not_empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Track fill level
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/vna_back.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator back end
// Sequencer over the position and sum memories with one shared multiplier,
// a bit-serial square root and a restoring divider for the unit normal.
// ----------------------------------------------------------------------------
`include "vertex_normal_accumulator_defines.svh"

module vna_back
   import vna_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  cmd_type                    cmd,
   output logic                       cmd_pop,
   input  logic [SCALE_W-1:0]         position_scale,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [IDX_W-1:0]           rsp_vertex_index,
   output logic signed [NORMAL_W-1:0] rsp_normal_x,
   output logic signed [NORMAL_W-1:0] rsp_normal_y,
   output logic signed [NORMAL_W-1:0] rsp_normal_z
);

   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int EXT_W = (AW > IDX_W) ? AW : IDX_W;
   localparam int POS_W = 3 * COORD_W;
   localparam int SUM_W = 3 * 64;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCALE = 4'd1;
   localparam logic [3:0] S_TRD   = 4'd2;
   localparam logic [3:0] S_CROSS = 4'd3;
   localparam logic [3:0] S_ACC   = 4'd4;
   localparam logic [3:0] S_RSUM  = 4'd5;
   localparam logic [3:0] S_MAG   = 4'd6;
   localparam logic [3:0] S_SHIFT = 4'd7;
   localparam logic [3:0] S_SQ    = 4'd8;
   localparam logic [3:0] S_SQRT  = 4'd9;
   localparam logic [3:0] S_DIV   = 4'd10;
   localparam logic [3:0] S_EMIT  = 4'd11;

   // Round a Q20.20 product to Q12.12 and saturate
   function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [65:0] p);
      logic signed [41:0] biased;
      logic signed [33:0] q;
      biased = $signed({p[40], p[40:0]}) + 42'sd128;
      q      = biased[41:8];
      if (q > 34'sd8388607) begin
         return 24'sd8388607;
      end
      if (q < -34'sd8388608) begin
         return -24'sd8388608;
      end
      return q[COORD_W-1:0];
   endfunction

   // Saturating add of a cross product component to a 64-bit sum
   function automatic logic [63:0] sat_add(input logic [63:0] s, input logic signed [51:0] d);
      logic [64:0] t;
      t = {s[63], s} + {{13{d[51]}}, d};
      if (t[64] != t[63]) begin
         return t[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end
      return t[63:0];
   endfunction

   // Magnitude of a signed 64-bit sum
   function automatic logic [63:0] mag64(input logic [63:0] s);
      return s[63] ? (~s + 64'd1) : s;
   endfunction

   // Sequencer state
   logic [3:0]  state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   cmd_type     cmd_ff, cmd_in;
   logic [AW-1:0] load_ptr_ff, load_ptr_in;

   // Datapath registers
   logic signed [COORD_W-1:0] sc_ff [2];
   logic signed [COORD_W-1:0] sc_in [2];
   logic [POS_W-1:0]          pa_ff, pa_in;
   logic signed [24:0]        u_ff [3];
   logic signed [24:0]        u_in [3];
   logic signed [24:0]        v_ff [3];
   logic signed [24:0]        v_in [3];
   logic signed [51:0]        cr_ff [3];
   logic signed [51:0]        cr_in [3];
   logic [63:0]               m_ff [3];
   logic [63:0]               m_in [3];
   logic [2:0]                sg_ff, sg_in;
   logic [63:0]               top_ff, top_in;
   logic [63:0]               sq_ff, sq_in;
   logic [63:0]               sv_ff, sv_in;
   logic [63:0]               root_ff, root_in;
   logic [63:0]               bit_ff, bit_in;
   logic [1:0]                div_k_ff, div_k_in;
   logic [47:0]               rem_ff, rem_in;
   logic [47:0]               dsr_ff, dsr_in;
   logic [15:0]               quo_ff, quo_in;
   logic signed [NORMAL_W-1:0] nrm_ff [3];
   logic signed [NORMAL_W-1:0] nrm_in [3];
   logic signed [65:0]        prod_ff;
   logic signed [32:0]        mul_a;
   logic signed [32:0]        mul_b;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]           rsp_vidx_ff, rsp_vidx_in;
   logic signed [NORMAL_W-1:0] rsp_nx_ff, rsp_nx_in;
   logic signed [NORMAL_W-1:0] rsp_ny_ff, rsp_ny_in;
   logic signed [NORMAL_W-1:0] rsp_nz_ff, rsp_nz_in;

   // Memories
   logic [POS_W-1:0] pos_mem [MAX_VERTICES];
   logic [SUM_W-1:0] sum_mem [MAX_VERTICES];
   logic [POS_W-1:0] pos_rd_ff;
   logic [SUM_W-1:0] sum_rd_ff;
   logic             pos_we, pos_re, sum_we, sum_re;
   logic [AW-1:0]    pos_waddr, pos_raddr, sum_waddr, sum_raddr;
   logic [POS_W-1:0] pos_wdata;
   logic [SUM_W-1:0] sum_wdata;

   // Corner addresses
   logic [EXT_W-1:0] a_ext, b_ext, c_ext;
   logic [AW-1:0]    a_addr, b_addr, c_addr, k_addr;

   // Scratch values
   logic signed [COORD_W-1:0] coord_sel;
   logic signed [COORD_W-1:0] rounded;
   logic [2:0]                cj;
   logic [1:0]                cc;
   logic signed [51:0]        prod_ext;
   logic [63:0]               m0, m1, m2, t01;
   logic [63:0]               sq_next;
   logic [63:0]               sqrt_t;
   logic [63:0]               m_sel;
   logic [31:0]               n_val;
   logic [15:0]               q_clip;

   assign a_ext  = EXT_W'(cmd_ff.corner_a);
   assign b_ext  = EXT_W'(cmd_ff.corner_b);
   assign c_ext  = EXT_W'(cmd_ff.corner_c);
   assign a_addr = a_ext[AW-1:0];
   assign b_addr = b_ext[AW-1:0];
   assign c_addr = c_ext[AW-1:0];

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_vertex_index = rsp_vidx_ff;
   assign rsp_normal_x     = rsp_nx_ff;
   assign rsp_normal_y     = rsp_ny_ff;
   assign rsp_normal_z     = rsp_nz_ff;

   assign rounded  = round_sat(prod_ff);
   assign prod_ext = {{2{prod_ff[49]}}, prod_ff[49:0]};
   assign n_val    = root_ff[31:0];

   // Sequencer and datapath next state
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      cmd_in      = cmd_ff;
      load_ptr_in = load_ptr_ff;
      sc_in       = sc_ff;
      pa_in       = pa_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      cr_in       = cr_ff;
      m_in        = m_ff;
      sg_in       = sg_ff;
      top_in      = top_ff;
      sq_in       = sq_ff;
      sv_in       = sv_ff;
      root_in     = root_ff;
      bit_in      = bit_ff;
      div_k_in    = div_k_ff;
      rem_in      = rem_ff;
      dsr_in      = dsr_ff;
      quo_in      = quo_ff;
      nrm_in      = nrm_ff;
      mul_a       = '0;
      mul_b       = '0;
      pos_we      = 1'b0;
      pos_re      = 1'b0;
      pos_waddr   = load_ptr_ff;
      pos_raddr   = a_addr;
      pos_wdata   = '0;
      sum_we      = 1'b0;
      sum_re      = 1'b0;
      sum_waddr   = load_ptr_ff;
      sum_raddr   = a_addr;
      sum_wdata   = '0;
      cmd_pop     = 1'b0;
      coord_sel   = cmd_ff.coord_x;
      cj          = step_ff[2:0] - 3'd1;
      cc          = cj[2:1];
      k_addr      = a_addr;
      m0          = mag64(sum_rd_ff[191:128]);
      m1          = mag64(sum_rd_ff[127:64]);
      m2          = mag64(sum_rd_ff[63:0]);
      t01         = (m_ff[0] > m_ff[1]) ? m_ff[0] : m_ff[1];
      sq_next     = sq_ff + prod_ff[63:0];
      sqrt_t      = root_ff + bit_ff;
      m_sel       = m_ff[0];
      q_clip      = (quo_ff > 16'd16384) ? 16'd16384 : quo_ff;

      // Drop the result once it is taken
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_vidx_in   = rsp_vidx_ff;
      rsp_nx_in     = rsp_nx_ff;
      rsp_ny_in     = rsp_ny_ff;
      rsp_nz_in     = rsp_nz_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               step_in = '0;
               nrm_in  = '{default: '0};
               case (cmd.kind)
                  KIND_LOAD: state_in = S_SCALE;
                  KIND_TRI:  state_in = S_TRD;
                  KIND_READ: state_in = S_RSUM;
                  default:   state_in = S_EMIT;
               endcase
            end
         end

         // Scale the three coordinates through the multiplier, then store
         S_SCALE: begin
            case (step_ff[1:0])
               2'd0:    coord_sel = cmd_ff.coord_x;
               2'd1:    coord_sel = cmd_ff.coord_y;
               default: coord_sel = cmd_ff.coord_z;
            endcase
            mul_a = {{9{coord_sel[COORD_W-1]}}, coord_sel};
            mul_b = $signed({17'b0, position_scale});
            if (step_ff == 5'd1) begin
               sc_in[0] = rounded;
            end
            if (step_ff == 5'd2) begin
               sc_in[1] = rounded;
            end
            if (step_ff == 5'd3) begin
               pos_we      = 1'b1;
               pos_wdata   = {sc_ff[0], sc_ff[1], rounded};
               sum_we      = 1'b1;
               sum_wdata   = '0;
               load_ptr_in = load_ptr_ff + 1'b1;
               state_in    = S_EMIT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end

         // Read the three corners and form the edge vectors
         S_TRD: begin
            case (step_ff[1:0])
               2'd0: begin
                  pos_re    = 1'b1;
                  pos_raddr = a_addr;
               end
               2'd1: begin
                  pos_re    = 1'b1;
                  pos_raddr = b_addr;
                  pa_in     = pos_rd_ff;
               end
               2'd2: begin
                  pos_re    = 1'b1;
                  pos_raddr = c_addr;
                  u_in[0] = $signed({pos_rd_ff[71], pos_rd_ff[71:48]})
                          - $signed({pa_ff[71], pa_ff[71:48]});
                  u_in[1] = $signed({pos_rd_ff[47], pos_rd_ff[47:24]})
                          - $signed({pa_ff[47], pa_ff[47:24]});
                  u_in[2] = $signed({pos_rd_ff[23], pos_rd_ff[23:0]})
                          - $signed({pa_ff[23], pa_ff[23:0]});
               end
               default: begin
                  v_in[0] = $signed({pos_rd_ff[71], pos_rd_ff[71:48]})
                          - $signed({pa_ff[71], pa_ff[71:48]});
                  v_in[1] = $signed({pos_rd_ff[47], pos_rd_ff[47:24]})
                          - $signed({pa_ff[47], pa_ff[47:24]});
                  v_in[2] = $signed({pos_rd_ff[23], pos_rd_ff[23:0]})
                          - $signed({pa_ff[23], pa_ff[23:0]});
                  state_in = S_CROSS;
               end
            endcase
            if (step_ff != 5'd3) begin
               step_in = step_ff + 5'd1;
            end else begin
               step_in = '0;
            end
         end

         // Six products, accumulated in pairs into the cross product
         S_CROSS: begin
            case (step_ff[2:0])
               3'd0: begin mul_a = 33'(u_ff[1]); mul_b = 33'(v_ff[2]); end
               3'd1: begin mul_a = 33'(u_ff[2]); mul_b = 33'(v_ff[1]); end
               3'd2: begin mul_a = 33'(u_ff[2]); mul_b = 33'(v_ff[0]); end
               3'd3: begin mul_a = 33'(u_ff[0]); mul_b = 33'(v_ff[2]); end
               3'd4: begin mul_a = 33'(u_ff[0]); mul_b = 33'(v_ff[1]); end
               3'd5: begin mul_a = 33'(u_ff[1]); mul_b = 33'(v_ff[0]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
            if (step_ff != 5'd0) begin
               if (!cj[0]) begin
                  cr_in[cc] = prod_ext;
               end else begin
                  cr_in[cc] = cr_ff[cc] - prod_ext;
               end
            end
            if (step_ff == 5'd6) begin
               step_in  = '0;
               state_in = S_ACC;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end

         // Read-modify-write the sum of each corner in turn
         S_ACC: begin
            case (step_ff[2:1])
               2'd0:    k_addr = a_addr;
               2'd1:    k_addr = b_addr;
               default: k_addr = c_addr;
            endcase
            if (!step_ff[0]) begin
               sum_re    = 1'b1;
               sum_raddr = k_addr;
            end else begin
               sum_we    = 1'b1;
               sum_waddr = k_addr;
               sum_wdata = {sat_add(sum_rd_ff[191:128], cr_ff[0]),
                            sat_add(sum_rd_ff[127:64], cr_ff[1]),
                            sat_add(sum_rd_ff[63:0], cr_ff[2])};
            end
            if (step_ff == 5'd5) begin
               state_in = S_EMIT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end

         // Fetch the sum and take magnitudes
         S_RSUM: begin
            if (step_ff == 5'd0) begin
               sum_re    = 1'b1;
               sum_raddr = a_addr;
               step_in   = 5'd1;
            end else begin
               m_in[0]  = m0;
               m_in[1]  = m1;
               m_in[2]  = m2;
               sg_in    = {sum_rd_ff[191], sum_rd_ff[127], sum_rd_ff[63]};
               state_in = S_MAG;
            end
         end

         S_MAG: begin
            top_in   = (t01 > m_ff[2]) ? t01 : m_ff[2];
            state_in = S_SHIFT;
         end

         // Shift one bit a cycle until the largest lies in [2^30, 2^31); emit if all zero
         S_SHIFT: begin
            if (top_ff == '0) begin
               state_in = S_EMIT;
            end else if (top_ff[63:31] != '0) begin
               top_in  = top_ff >> 1;
               m_in[0] = m_ff[0] >> 1;
               m_in[1] = m_ff[1] >> 1;
               m_in[2] = m_ff[2] >> 1;
            end else if (!top_ff[30]) begin
               top_in  = top_ff << 1;
               m_in[0] = m_ff[0] << 1;
               m_in[1] = m_ff[1] << 1;
               m_in[2] = m_ff[2] << 1;
            end else begin
               step_in  = '0;
               state_in = S_SQ;
            end
         end

         // Sum of squares through the multiplier
         S_SQ: begin
            case (step_ff[1:0])
               2'd0:    m_sel = m_ff[0];
               2'd1:    m_sel = m_ff[1];
               default: m_sel = m_ff[2];
            endcase
            mul_a = $signed({2'b0, m_sel[30:0]});
            mul_b = $signed({2'b0, m_sel[30:0]});
            if (step_ff == 5'd1) begin
               sq_in = prod_ff[63:0];
            end else if (step_ff != 5'd0) begin
               sq_in = sq_next;
            end
            if (step_ff == 5'd3) begin
               sv_in    = sq_next;
               root_in  = '0;
               bit_in   = 64'd1 << 62;
               step_in  = '0;
               state_in = S_SQRT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end

         // Floor square root, one result bit a cycle
         S_SQRT: begin
            if (sv_ff >= sqrt_t) begin
               sv_in   = sv_ff - sqrt_t;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (step_ff == 5'd31) begin
               step_in  = '0;
               div_k_in = '0;
               state_in = S_DIV;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end

         // Rounded quotient |v| * 16384 / n, one bit a cycle, per component
         S_DIV: begin
            case (div_k_ff)
               2'd0:    m_sel = m_ff[0];
               2'd1:    m_sel = m_ff[1];
               default: m_sel = m_ff[2];
            endcase
            if (step_ff == 5'd0) begin
               rem_in  = {3'b0, m_sel[30:0], 14'b0} + {17'b0, n_val[31:1]};
               dsr_in  = {1'b0, n_val, 15'b0};
               quo_in  = '0;
               step_in = 5'd1;
            end else if (step_ff != 5'd17) begin
               if (rem_ff >= dsr_ff) begin
                  rem_in = rem_ff - dsr_ff;
                  quo_in = {quo_ff[14:0], 1'b1};
               end else begin
                  quo_in = {quo_ff[14:0], 1'b0};
               end
               dsr_in  = dsr_ff >> 1;
               step_in = step_ff + 5'd1;
            end else begin
               nrm_in[div_k_ff] = sg_ff[2'd2 - div_k_ff] ? $signed(~q_clip + 16'd1)
                                                         : $signed(q_clip);
               step_in = '0;
               if (div_k_ff == 2'd2) begin
                  state_in = S_EMIT;
               end else begin
                  div_k_in = div_k_ff + 2'd1;
               end
            end
         end

         // Hand the result to the output register when it is free
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cmd_ff.status;
               rsp_vidx_in   = cmd_ff.vidx;
               rsp_nx_in     = nrm_ff[0];
               rsp_ny_in     = nrm_ff[1];
               rsp_nz_in     = nrm_ff[2];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         load_ptr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         div_k_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         load_ptr_ff  <= load_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         div_k_ff     <= div_k_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      sc_ff         <= sc_in;
      pa_ff         <= pa_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      cr_ff         <= cr_in;
      m_ff          <= m_in;
      sg_ff         <= sg_in;
      top_ff        <= top_in;
      sq_ff         <= sq_in;
      sv_ff         <= sv_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      rem_ff        <= rem_in;
      dsr_ff        <= dsr_in;
      quo_ff        <= quo_in;
      nrm_ff        <= nrm_in;
      prod_ff       <= mul_a * mul_b;
      rsp_status_ff <= rsp_status_in;
      rsp_vidx_ff   <= rsp_vidx_in;
      rsp_nx_ff     <= rsp_nx_in;
      rsp_ny_ff     <= rsp_ny_in;
      rsp_nz_ff     <= rsp_nz_in;
   end

   // Position memory
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      if (pos_re) begin
         pos_rd_ff <= pos_mem[pos_raddr];
      end
   end

   // Normal sum memory, cleared entry by entry as vertices load
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      if (sum_re) begin
         sum_rd_ff <= sum_mem[sum_raddr];
      end
   end

   `VNA_ASSERT_HOLDS(a_sq_range, state_ff == S_SQ,
      m_ff[0][63:31] == '0 && m_ff[1][63:31] == '0 && m_ff[2][63:31] == '0,
      "normalized magnitude out of range")
   `VNA_ASSERT_HOLDS(a_div_nonzero, state_ff == S_DIV, root_ff != '0,
      "divide by a zero length")
   `VNA_ASSERT_NEXT(a_sqrt_to_div, state_ff == S_SQRT && step_ff == 5'd31,
      state_ff == S_DIV && step_ff == 5'd0, "square root did not hand over to divider")

endmodule

// ===== rtl/vertex_normal_accumulator.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Area-weighted vertex normals: loads scaled positions, accumulates triangle
// cross products per corner and returns unit normals in Q1.14.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  mode, coords, corners
//   rsp_      out        rsp_valid/rsp_stall  status, index, normal
//   csr       in         psel/penable/pready  position_scale at byte 0
//
// A read of an all-zero sum skips the normalization; any other read runs
// the one-bit normalizing shifter, the 32-step square root and the
// divider, run once per component.
// Reset is synchronous; sums are zeroed as each vertex loads, no clearing pass.
// The front takes beats while the back works, up to a two-beat queue.
// A stalled result holds in the output register while the next item runs.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator
   import vna_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_mode,
   input  logic signed [COORD_W-1:0]  req_coord_x,
   input  logic signed [COORD_W-1:0]  req_coord_y,
   input  logic signed [COORD_W-1:0]  req_coord_z,
   input  logic [IDX_W-1:0]           req_corner_a,
   input  logic [IDX_W-1:0]           req_corner_b,
   input  logic [IDX_W-1:0]           req_corner_c,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [IDX_W-1:0]           rsp_vertex_index,
   output logic signed [NORMAL_W-1:0] rsp_normal_x,
   output logic signed [NORMAL_W-1:0] rsp_normal_y,
   output logic signed [NORMAL_W-1:0] rsp_normal_z,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_W-1:0]      paddr,
   input  logic [CSR_DATA_W-1:0]      pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic [SCALE_W-1:0] scale_ff;
   logic [SCALE_W-1:0] scale_in;
   logic               scale_hit;
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_not_empty;
   cmd_type            q_push_cmd;
   cmd_type            q_pop_cmd;

   // Configuration register
   assign pready    = 1'b1;
   assign scale_hit = (paddr[CSR_ADDR_W-1:2] == REG_POSITION_SCALE);
   assign prdata    = scale_hit ? CSR_DATA_W'(scale_ff) : '0;

   always_comb begin
      scale_in = scale_ff;
      if (psel && penable && pwrite && scale_hit) begin
         scale_in = pwdata[SCALE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   vna_front #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .req_coord_z  (req_coord_z),
      .req_corner_a (req_corner_a),
      .req_corner_b (req_corner_b),
      .req_corner_c (req_corner_c),
      .queue_full   (q_full),
      .queue_push   (q_push),
      .queue_cmd    (q_push_cmd)
   );

   vna_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_cmd   (q_pop_cmd),
      .not_empty (q_not_empty)
   );

   vna_back #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (q_not_empty),
      .cmd              (q_pop_cmd),
      .cmd_pop          (q_pop),
      .position_scale   (scale_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z)
   );

endmodule

// ===== sim/vertex_normal_accumulator_checker.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator checker
// Watches the request, result and register ports, predicts every result
// beat from its own copy of positions, sums and scale, and compares.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_checker
   import vna_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [1:0]                 req_mode,
   input  logic signed [COORD_W-1:0]  req_coord_x,
   input  logic signed [COORD_W-1:0]  req_coord_y,
   input  logic signed [COORD_W-1:0]  req_coord_z,
   input  logic [IDX_W-1:0]           req_corner_a,
   input  logic [IDX_W-1:0]           req_corner_b,
   input  logic [IDX_W-1:0]           req_corner_c,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [1:0]                 rsp_status,
   input  logic [IDX_W-1:0]           rsp_vertex_index,
   input  logic signed [NORMAL_W-1:0] rsp_normal_x,
   input  logic signed [NORMAL_W-1:0] rsp_normal_y,
   input  logic signed [NORMAL_W-1:0] rsp_normal_z,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_W-1:0]      paddr,
   input  logic [CSR_DATA_W-1:0]      pwdata,
   input  logic                       pready,
   output int                         fail_count,
   output int                         pending
);

   typedef struct {
      logic [1:0]                status;
      logic [IDX_W-1:0]          vidx;
      logic signed [NORMAL_W-1:0] nx;
      logic signed [NORMAL_W-1:0] ny;
      logic signed [NORMAL_W-1:0] nz;
   } normal_beat_type;

   logic signed [COORD_W-1:0] pos_x [MAX_VERTICES];
   logic signed [COORD_W-1:0] pos_y [MAX_VERTICES];
   logic signed [COORD_W-1:0] pos_z [MAX_VERTICES];
   longint                    acc_x [MAX_VERTICES];
   longint                    acc_y [MAX_VERTICES];
   longint                    acc_z [MAX_VERTICES];
   int                        loaded_total;
   logic [SCALE_W-1:0]        scale;
   normal_beat_type           expected_normals [$];

   assign pending = expected_normals.size();

   // Q12.12 times unsigned Q8.8, rounded back to Q12.12 and saturated
   function automatic logic signed [COORD_W-1:0] scaled_coord(
      logic signed [COORD_W-1:0] c, logic [SCALE_W-1:0] s);
      longint p;
      p = (longint'(c) * longint'({1'b0, s}) + 128) >>> 8;
      if (p > 64'sd8388607) p = 64'sd8388607;
      if (p < -64'sd8388608) p = -64'sd8388608;
      return p[COORD_W-1:0];
   endfunction

   function automatic longint clamped_sum(longint a, longint b);
      longint r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63])
         r = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return r;
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // Normalize the sum to unit length in Q1.14
   function automatic void unit_vector(longint sx, longint sy, longint sz,
                                       ref normal_beat_type beat);
      longint      s [3];
      logic [63:0] m [3];
      logic [63:0] top, sq, n, q;
      int          rs, ls;
      logic signed [NORMAL_W-1:0] o [3];
      s[0] = sx; s[1] = sy; s[2] = sz;
      rs = 0; ls = 0;
      for (int i = 0; i < 3; i++) m[i] = s[i] < 0 ? 64'd0 - s[i] : s[i];
      top = m[0];
      if (m[1] > top) top = m[1];
      if (m[2] > top) top = m[2];
      if (top == 0) begin
         beat.nx = 0; beat.ny = 0; beat.nz = 0;
         return;
      end
      while (top >= (64'd1 << 31)) begin top = top >> 1; rs++; end
      while (top < (64'd1 << 30)) begin top = top << 1; ls++; end
      for (int i = 0; i < 3; i++) m[i] = (m[i] >> rs) << ls;
      sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      n = floor_root(sq);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * 64'd16384 + n / 2) / n;
         if (q > 64'd16384) q = 64'd16384;
         o[i] = s[i] < 0 ? -q[NORMAL_W-1:0] : q[NORMAL_W-1:0];
      end
      beat.nx = o[0]; beat.ny = o[1]; beat.nz = o[2];
   endfunction

   // Advance the mirrored state by one request beat and return its result
   function automatic normal_beat_type predict_normal_beat();
      normal_beat_type r;
      int              k [3];
      longint          ux, uy, uz, vx, vy, vz, cx, cy, cz;
      r = '{STATUS_OK, '0, 0, 0, 0};
      k[0] = req_corner_a; k[1] = req_corner_b; k[2] = req_corner_c;
      case (req_mode)
         MODE_LOAD: begin
            if (loaded_total >= MAX_VERTICES) begin
               r.status = STATUS_FULL;
            end else begin
               pos_x[loaded_total] = scaled_coord(req_coord_x, scale);
               pos_y[loaded_total] = scaled_coord(req_coord_y, scale);
               pos_z[loaded_total] = scaled_coord(req_coord_z, scale);
               acc_x[loaded_total] = 0;
               acc_y[loaded_total] = 0;
               acc_z[loaded_total] = 0;
               r.vidx = loaded_total[IDX_W-1:0];
               loaded_total++;
            end
         end
         MODE_TRI: begin
            r.vidx = req_corner_a;
            if (k[0] >= loaded_total || k[1] >= loaded_total ||
                k[2] >= loaded_total) begin
               r.status = STATUS_UNLOADED;
            end else begin
               ux = longint'(pos_x[k[1]]) - pos_x[k[0]];
               uy = longint'(pos_y[k[1]]) - pos_y[k[0]];
               uz = longint'(pos_z[k[1]]) - pos_z[k[0]];
               vx = longint'(pos_x[k[2]]) - pos_x[k[0]];
               vy = longint'(pos_y[k[2]]) - pos_y[k[0]];
               vz = longint'(pos_z[k[2]]) - pos_z[k[0]];
               cx = uy * vz - uz * vy;
               cy = uz * vx - ux * vz;
               cz = ux * vy - uy * vx;
               for (int i = 0; i < 3; i++) begin
                  acc_x[k[i]] = clamped_sum(acc_x[k[i]], cx);
                  acc_y[k[i]] = clamped_sum(acc_y[k[i]], cy);
                  acc_z[k[i]] = clamped_sum(acc_z[k[i]], cz);
               end
            end
         end
         MODE_READ: begin
            r.vidx = req_corner_a;
            if (k[0] >= loaded_total) r.status = STATUS_UNLOADED;
            else unit_vector(acc_x[k[0]], acc_y[k[0]], acc_z[k[0]], r);
         end
         default: r.status = STATUS_UNLOADED;
      endcase
      return r;
   endfunction

   initial fail_count = 0;

   // Compare result beats first, then record request beats and register writes
   always @(posedge clock) begin
      normal_beat_type e;
      if (reset) begin
         loaded_total = 0;
         scale = SCALE_RESET;
         expected_normals.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_normals.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat status %0d index %0d", $time,
                        rsp_status, rsp_vertex_index);
            end else begin
               e = expected_normals.pop_front();
               if (rsp_status !== e.status || rsp_vertex_index !== e.vidx ||
                   rsp_normal_x !== e.nx || rsp_normal_y !== e.ny ||
                   rsp_normal_z !== e.nz) begin
                  fail_count++;
                  $display("%0t: expected st %0d idx %0d n (%0d %0d %0d),",
                           $time, e.status, e.vidx, e.nx, e.ny, e.nz,
                           " got st %0d idx %0d n (%0d %0d %0d)", rsp_status,
                           rsp_vertex_index, rsp_normal_x, rsp_normal_y, rsp_normal_z);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_normals.insert(expected_normals.size(), predict_normal_beat());
         if (psel && penable && pwrite && pready &&
             paddr == {REG_POSITION_SCALE, 2'b00})
            scale = pwdata[SCALE_W-1:0];
      end
   end

endmodule

// ===== sim/vertex_normal_accumulator_tb.sv =====
// ----------------------------------------------------------------------------
// Vertex normal accumulator testbench
// Drives directed and random load, triangle and read beats under several
// idle and stall patterns and scale settings; the checker gives the verdict.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_tb;
   import vna_pkg::*;

   localparam logic [1:0] MODE_NONE  = 2'd3;
   localparam int         IDLE_LIMIT = 20000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_mode = MODE_LOAD;
   logic signed [COORD_W-1:0]  req_coord_x = '0;
   logic signed [COORD_W-1:0]  req_coord_y = '0;
   logic signed [COORD_W-1:0]  req_coord_z = '0;
   logic [IDX_W-1:0]           req_corner_a = '0;
   logic [IDX_W-1:0]           req_corner_b = '0;
   logic [IDX_W-1:0]           req_corner_c = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [1:0]                 rsp_status;
   logic [IDX_W-1:0]           rsp_vertex_index;
   logic signed [NORMAL_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic                       psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      paddr = '0;
   logic [CSR_DATA_W-1:0]      pwdata = '0;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;
   int                         fail_count, pending;
   int                         idle_pct = 0, stall_pct = 0, hold_cycles = 0;
   int                         loads_sent = 0, quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   vertex_normal_accumulator u_top (.*);

   vertex_normal_accumulator_checker u_checker (.*);

   // Receiver: long hold-off when asked, otherwise random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall = $urandom_range(0, 99) < stall_pct;
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         quiet_cycles = 0;
      else if (!reset)
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_beat(logic [1:0] mode, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                            int a, int b, int c);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_mode = mode;
      req_coord_x = x; req_coord_y = y; req_coord_z = z;
      req_corner_a = IDX_W'(a); req_corner_b = IDX_W'(b); req_corner_c = IDX_W'(c);
      req_valid = 1'b1;
      if (mode == MODE_LOAD) loads_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic load_vertex(int x, int y, int z);
      send_beat(MODE_LOAD, COORD_W'(x), COORD_W'(y), COORD_W'(z), 0, 0, 0);
   endtask

   // Drain, let the block settle, then write the scale register
   task automatic write_scale(logic [SCALE_W-1:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (150) @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; pwdata = CSR_DATA_W'(value);
      paddr = {REG_POSITION_SCALE, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   function automatic int pick_corner(int valid_pct);
      if (loads_sent > 0 && $urandom_range(0, 99) < valid_pct)
         return $urandom_range(0, (loads_sent > 1024 ? 1024 : loads_sent) - 1);
      return $urandom_range(0, 1023);
   endfunction

   task automatic random_beat();
      int r;
      logic signed [COORD_W-1:0] x, y, z;
      r = $urandom_range(0, 99);
      x = COORD_W'($urandom); y = COORD_W'($urandom); z = COORD_W'($urandom);
      if ($urandom_range(0, 1)) begin
         x = $signed(x) >>> 9; y = $signed(y) >>> 9; z = $signed(z) >>> 9;
      end
      if (r < 55)
         load_vertex(x, y, z);
      else if (r < 80)
         send_beat(MODE_TRI, 0, 0, 0, pick_corner(92), pick_corner(92), pick_corner(92));
      else if (r < 96)
         send_beat(MODE_READ, x, y, z, pick_corner(88), $urandom, $urandom);
      else
         send_beat(MODE_NONE, x, y, z, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int idle_set  [6] = '{0, 88, 0, 17, 0, 0};
      int stall_set [6] = '{0, 0, 88, 17, 0, 40};
      logic [SCALE_W-1:0] scale_set [6] = '{16'd256, 16'd65535, 16'd0, 16'd384,
                                            16'd256, 16'd200};
      int wait_count;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: unloaded indices, unknown mode, extreme positions, normals
      send_beat(MODE_READ, 0, 0, 0, 0, 0, 0);
      send_beat(MODE_TRI, 0, 0, 0, 0, 1, 2);
      send_beat(MODE_NONE, -1, -1, -1, 1023, 1023, 1023);
      load_vertex(0, 0, 0);
      load_vertex(4096, 0, 0);
      load_vertex(0, 4096, 0);
      load_vertex(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
      load_vertex(-24'sh800000, -24'sh800000, -24'sh800000);
      send_beat(MODE_READ, 0, 0, 0, 0, 0, 0);
      send_beat(MODE_TRI, 0, 0, 0, 0, 1, 2);
      send_beat(MODE_READ, 0, 0, 0, 0, 0, 0);
      send_beat(MODE_READ, 0, 0, 0, 1, 0, 0);
      send_beat(MODE_TRI, 0, 0, 0, 0, 0, 1);
      send_beat(MODE_TRI, 0, 0, 0, 3, 4, 1);
      send_beat(MODE_READ, 0, 0, 0, 3, 0, 0);
      send_beat(MODE_READ, 0, 0, 0, 4, 0, 0);
      send_beat(MODE_TRI, 0, 0, 0, 0, 1, 9);
      send_beat(MODE_READ, 0, 0, 0, 1023, 0, 0);
      write_scale(16'd65535);
      load_vertex(24'sh7FFFFF, -24'sh800000, 24'sh000100);
      write_scale(16'd0);
      load_vertex(24'sh7FFFFF, -24'sh800000, 24'sh123456);
      send_beat(MODE_TRI, 0, 0, 0, 5, 6, 4);
      send_beat(MODE_READ, 0, 0, 0, 5, 0, 0);

      // Random phases with idle, stall, hold-off and scale changes
      for (int p = 0; p < 6; p++) begin
         write_scale(scale_set[p]);
         idle_pct = idle_set[p];
         stall_pct = stall_set[p];
         if (p == 4) hold_cycles = 400;
         repeat (230) random_beat();
      end

      // Fill the vertex store and push past it
      idle_pct = 0; stall_pct = 10;
      write_scale(16'd256);
      while (loads_sent < 1028) load_vertex($urandom, $urandom, $urandom);
      send_beat(MODE_TRI, 0, 0, 0, 1021, 1022, 1023);
      send_beat(MODE_READ, 0, 0, 0, 1023, 0, 0);
      send_beat(MODE_READ, 0, 0, 0, 1022, 0, 0);
      @(negedge clock);
      req_valid = 1'b0;

      wait_count = 0;
      while (pending != 0 && wait_count < IDLE_LIMIT * 4) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
